[src/mse_pkg.sv]
// Shared types and constants for the magstripe F2F track encoder.
package mse_pkg;

  localparam int TRACK1_BITS = 7;
  localparam int TRACK2_BITS = 5;

  localparam int CODE_W  = 7;
  localparam int COUNT_W = 5;
  localparam int LRC_W   = 7;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    FUNC_CHAR  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_END   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_TRACK_MODE = 2'd0,
    REG_LRC_VALUE  = 2'd1,
    REG_LEAD_ZERO  = 2'd2,
    REG_TRAIL_ZERO = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic               track_mode;
    logic [LRC_W-1:0]   lrc_value;
    logic [COUNT_W-1:0] lead_zero_count;
    logic [COUNT_W-1:0] trail_zero_count;
  } cfg_t;

  typedef struct packed {
    logic first_half;
    logic second_half;
    logic last;
  } cell_t;

endpackage

[src/mse_cfg_regs.sv]
// APB configuration registers of the magstripe encoder.
module mse_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mse_pkg::ADDR_W-1:0] paddr,
  input  logic [mse_pkg::DATA_W-1:0] pwdata,
  output logic [mse_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mse_pkg::cfg_t              cfg_o
);
  import mse_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TRACK_MODE: cfg_d.track_mode       = pwdata[0];
        REG_LRC_VALUE:  cfg_d.lrc_value        = pwdata[LRC_W-1:0];
        REG_LEAD_ZERO:  cfg_d.lead_zero_count  = pwdata[COUNT_W-1:0];
        REG_TRAIL_ZERO: cfg_d.trail_zero_count = pwdata[COUNT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRACK_MODE: prdata = DATA_W'(cfg_q.track_mode);
      REG_LRC_VALUE:  prdata = DATA_W'(cfg_q.lrc_value);
      REG_LEAD_ZERO:  prdata = DATA_W'(cfg_q.lead_zero_count);
      REG_TRAIL_ZERO: prdata = DATA_W'(cfg_q.trail_zero_count);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_mode       <= 1'b0;
      cfg_q.lrc_value        <= '0;
      cfg_q.lead_zero_count  <= COUNT_W'(25);
      cfg_q.trail_zero_count <= COUNT_W'(25);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/mse_cell_gen.sv]
// Item register and bit-cell serializer with line level and LRC tracking.
module mse_cell_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mse_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [mse_pkg::CODE_W-1:0] char_code_i,
  output logic                       cell_valid_o,
  input  logic                       cell_ready_i,
  output mse_pkg::cell_t             cell_o
);
  import mse_pkg::*;

  logic               act_q, act_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               level_q, level_d;
  logic               lrc_q, lrc_d;

  logic               fire, load;
  logic [COUNT_W-1:0] load_cnt;
  logic [CODE_W-1:0]  load_code;
  logic               load_lrc;
  logic               load_clr_level;

  assign cell_valid_o       = act_q;
  assign cell_o.first_half  = level_q;
  assign cell_o.second_half = level_q ^ code_q[0];
  assign cell_o.last        = (cnt_q == COUNT_W'(1));

  assign fire       = act_q && cell_ready_i;
  assign in_ready_o = !act_q || (fire && cell_o.last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    load_cnt       = '0;
    load_code      = '0;
    load_lrc       = lrc_q;
    load_clr_level = 1'b0;
    unique case (func_e'(func_i))
      FUNC_START: begin
        load_cnt       = cfg_i.lead_zero_count;
        load_lrc       = 1'b0;
        load_clr_level = 1'b1;
      end
      FUNC_END: begin
        load_cnt = cfg_i.trail_zero_count;
        load_lrc = 1'b0;
      end
      FUNC_CHAR: begin
        load_code = char_code_i;
        if (cfg_i.track_mode) begin
          load_cnt = COUNT_W'(TRACK2_BITS);
        end else if (!lrc_q) begin
          load_cnt = COUNT_W'(TRACK1_BITS);
          load_lrc = (char_code_i == cfg_i.lrc_value);
        end
      end
      default: begin
        load_cnt = '0;
      end
    endcase
  end

  always_comb begin
    act_d   = act_q;
    code_d  = code_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    lrc_d   = lrc_q;
    if (fire) begin
      level_d = ~cell_o.second_half;
      code_d  = code_q >> 1;
      cnt_d   = cnt_q - COUNT_W'(1);
      act_d   = !cell_o.last;
    end
    if (load) begin
      act_d  = (load_cnt != '0);
      code_d = load_code;
      cnt_d  = load_cnt;
      lrc_d  = load_lrc;
      if (load_clr_level) begin
        level_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      level_q <= 1'b0;
      lrc_q   <= 1'b0;
    end else begin
      act_q   <= act_d;
      level_q <= level_d;
      lrc_q   <= lrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    cnt_q  <= cnt_d;
  end

endmodule

[src/mse_out_reg.sv]
// Output register for bit cells.
module mse_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cell_valid_i,
  output logic           cell_ready_o,
  input  mse_pkg::cell_t cell_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mse_pkg::cell_t cell_o
);
  import mse_pkg::*;

  logic  valid_q, valid_d;
  cell_t cell_q, cell_d;

  assign cell_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign cell_o       = cell_q;

  always_comb begin
    valid_d = valid_q;
    cell_d  = cell_q;
    if (cell_ready_o) begin
      valid_d = cell_valid_i;
      cell_d  = cell_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

endmodule

[src/magstripe_f2f_track_encoder.sv]
// Top level of the magstripe F2F (Aiken biphase) track encoder.
// Each item is a start frame, a character or an end frame; it yields one bit
// cell per cycle unless the output stalls, through a registered output: 7 for a
// track-one character up to the LRC, 5 for track two, the lead or trail zero
// count for start and end, as the serializer's cell counter sets. The next item
// is taken in the cycle its predecessor's last cell leaves the serializer, or
// at once after an empty item. Registers lie at byte addresses 0, 4, 8, 12.
module magstripe_f2f_track_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mse_pkg::ADDR_W-1:0] paddr,
  input  logic [mse_pkg::DATA_W-1:0] pwdata,
  output logic [mse_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [mse_pkg::CODE_W-1:0] char_code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       first_half_o,
  output logic                       second_half_o,
  output logic                       last_o
);
  import mse_pkg::*;

  cfg_t  cfg;
  cell_t gen_cell, out_cell;
  logic  cell_valid, cell_ready;

  mse_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  mse_cell_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .cell_valid_o(cell_valid),
    .cell_ready_i(cell_ready),
    .cell_o      (gen_cell)
  );

  mse_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_valid_i(cell_valid),
    .cell_ready_o(cell_ready),
    .cell_i      (gen_cell),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_o      (out_cell)
  );

  assign first_half_o  = out_cell.first_half;
  assign second_half_o = out_cell.second_half;
  assign last_o        = out_cell.last;

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid && !cell_ready |=> cell_valid)
    else $error("serializer dropped a pending cell");

  a_busy_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid && cell_ready && !gen_cell.last |=> cell_valid && (!in_ready_o || gen_cell.last))
    else $error("new item accepted before the current one finished");

  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid && cell_ready && gen_cell.last |-> in_ready_o)
    else $error("input not ready when last cell leaves");

  a_level_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid && cell_ready && !gen_cell.last |=>
      gen_cell.first_half != $past(gen_cell.second_half))
    else $error("missing transition at cell boundary");

endmodule

[tb/sv/f2f_cell_model_pkg.sv]
// Bit-cell model of the F2F track encoder, with the queue of cells still to come out.
package f2f_cell_model_pkg;

  import mse_pkg::*;

  class f2f_cell_model;
    logic               track_mode;
    logic [LRC_W-1:0]   lrc_value;
    logic [COUNT_W-1:0] lead_zeros;
    logic [COUNT_W-1:0] trail_zeros;
    logic               line_level;
    logic               lrc_seen;
    cell_t              pending_cells[$];
    int                 failures;

    function new();
      track_mode  = 1'b0;
      lrc_value   = '0;
      lead_zeros  = COUNT_W'(25);
      trail_zeros = COUNT_W'(25);
      line_level  = 1'b0;
      lrc_seen    = 1'b0;
      failures    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_TRACK_MODE: track_mode  = value[0];
        REG_LRC_VALUE:  lrc_value   = value[LRC_W-1:0];
        REG_LEAD_ZERO:  lead_zeros  = value[COUNT_W-1:0];
        REG_TRAIL_ZERO: trail_zeros = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // one cell: first half at the line level, flip at mid cell for a one
    function void push_cell(logic bit_val, logic fin);
      cell_t c;
      c.first_half  = line_level;
      c.second_half = line_level ^ bit_val;
      c.last        = fin;
      pending_cells.push_back(c);
      line_level = ~c.second_half;
    endfunction

    // returns the number of cells the item produces
    function int note_item(logic [1:0] func, logic [CODE_W-1:0] code);
      int nbits;
      int k;
      nbits = 0;
      case (func)
        FUNC_START: begin
          line_level = 1'b0;
          lrc_seen   = 1'b0;
          nbits      = int'(lead_zeros);
          for (k = 0; k < nbits; k++) push_cell(1'b0, k == nbits - 1);
        end
        FUNC_END: begin
          lrc_seen = 1'b0;
          nbits    = int'(trail_zeros);
          for (k = 0; k < nbits; k++) push_cell(1'b0, k == nbits - 1);
        end
        FUNC_CHAR: begin
          if (track_mode || !lrc_seen) begin
            nbits = track_mode ? TRACK2_BITS : TRACK1_BITS;
            for (k = 0; k < nbits; k++) begin
              push_cell((k < CODE_W) ? code[k] : 1'b0, k == nbits - 1);
            end
            if (!track_mode && code == lrc_value) lrc_seen = 1'b1;
          end
        end
        default: ;
      endcase
      return nbits;
    endfunction

    function void check_cell(logic fh, logic sh, logic fin);
      cell_t want;
      if (pending_cells.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected cell: first=%0b second=%0b last=%0b", fh, sh, fin);
        end
      end else begin
        want = pending_cells.pop_front();
        if (want.first_half !== fh || want.second_half !== sh || want.last !== fin) begin
          failures++;
          if (failures <= 10) begin
            $display("cell mismatch: expected first=%0b second=%0b last=%0b, got %0b %0b %0b",
                     want.first_half, want.second_half, want.last, fh, sh, fin);
          end
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/testbench.sv]
// Testbench for the F2F track encoder: random frames and settings, cells checked against a model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;
  import f2f_cell_model_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 350;
  localparam int QUIET_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT_NS    = 20_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          func_i;
  logic [CODE_W-1:0]   char_code_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                first_half_o;
  logic                second_half_o;
  logic                last_o;

  f2f_cell_model line_model;
  int                  idle_odds;
  bit                  hold_request;
  int                  sent_count;

  magstripe_f2f_track_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_half_o  (first_half_o),
    .second_half_o (second_half_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    line_model.set_reg(idx, value);
  endtask

  task automatic offer_item(logic [1:0] func, logic [CODE_W-1:0] code);
    int gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    func_i      = func;
    char_code_i = code;
    do @(posedge clk_i); while (!in_ready_o);
    void'(line_model.note_item(func, code));
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (line_model.pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    int stall;
    stall       = 0;
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        line_model.check_cell(first_half_o, second_half_o, last_o);
      end
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = HOLD_CYCLES;
      end else if (stall == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall = $urandom_range(1, 10);
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    int phase;
    int frames;
    int f;
    int k;
    int nchars;
    int extra;
    int pick;
    logic [CODE_W-1:0] code;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_CHAR;
    char_code_i  = '0;
    idle_odds    = 4;
    hold_request = 1'b0;
    sent_count   = 0;
    line_model   = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: track one, LRC 0, 25 lead and trail zeros
    offer_item(FUNC_START, 7'h00);
    offer_item(FUNC_CHAR, 7'h7F);
    offer_item(FUNC_CHAR, 7'h55);
    offer_item(FUNC_CHAR, 7'h00);   // LRC itself is sent
    offer_item(FUNC_CHAR, 7'h2A);   // dropped after LRC
    offer_item(FUNC_UNUSED, 7'h7F);
    offer_item(FUNC_END, 7'h00);
    offer_item(FUNC_CHAR, 7'h01);   // end cleared the LRC flag
    wait_drained();

    write_reg(REG_TRACK_MODE, 1);
    write_reg(REG_LRC_VALUE, 127);
    write_reg(REG_LEAD_ZERO, 0);
    write_reg(REG_TRAIL_ZERO, 31);
    offer_item(FUNC_START, 7'h7F);  // no cells
    offer_item(FUNC_CHAR, 7'h7F);
    offer_item(FUNC_CHAR, 7'h00);
    offer_item(FUNC_CHAR, 7'h60);   // upper bits unused in track two
    offer_item(FUNC_UNUSED, 7'h00);
    offer_item(FUNC_END, 7'h55);
    wait_drained();

    write_reg(REG_TRACK_MODE, 0);
    write_reg(REG_LRC_VALUE, 127);
    write_reg(REG_LEAD_ZERO, 31);
    write_reg(REG_TRAIL_ZERO, 0);
    offer_item(FUNC_START, 7'h00);
    offer_item(FUNC_CHAR, 7'h7F);
    offer_item(FUNC_CHAR, 7'h01);
    offer_item(FUNC_END, 7'h00);    // no cells
    offer_item(FUNC_CHAR, 7'h7F);
    offer_item(FUNC_START, 7'h00);
    offer_item(FUNC_CHAR, 7'h3C);

    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      wait_drained();
      if (sent_count >= ITEM_TARGET - QUIET_ITEMS) begin
        idle_odds = 0;
      end else begin
        idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      end
      write_reg(REG_TRACK_MODE, $urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      write_reg(REG_LRC_VALUE, (pick == 0) ? 0 : (pick == 1) ? 127 : $urandom_range(0, 127));
      pick = $urandom_range(0, 9);
      write_reg(REG_LEAD_ZERO, (pick == 0) ? 0 : (pick == 1) ? 31 : $urandom_range(1, 6));
      pick = $urandom_range(0, 9);
      write_reg(REG_TRAIL_ZERO, (pick == 0) ? 0 : (pick == 1) ? 31 : $urandom_range(1, 6));
      if (phase == 1) hold_request = 1'b1;

      frames = (phase == 1) ? 4 : $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        nchars = $urandom_range(1, 10);
        if ($urandom_range(0, 7) != 0) offer_item(FUNC_START, CODE_W'($urandom));
        for (k = 0; k < nchars; k++) begin
          code = CODE_W'($urandom);
          if (!line_model.track_mode && k == nchars - 1 && $urandom_range(0, 2) != 0) begin
            code = line_model.lrc_value;
          end
          if ($urandom_range(0, 15) == 0) begin
            offer_item(2'($urandom_range(0, 3)), CODE_W'($urandom));
          end
          offer_item(FUNC_CHAR, code);
        end
        extra = $urandom_range(0, 2);
        for (k = 0; k < extra; k++) offer_item(FUNC_CHAR, CODE_W'($urandom));
        if ($urandom_range(0, 7) != 0) offer_item(FUNC_END, CODE_W'($urandom));
      end
      phase++;
    end

    wait_drained();
    if (line_model.failures == 0 && line_model.pending_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
